/* design/bls_pkg.sv */
package bls_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int VP_W = 13;

    localparam logic [VP_W-1:0] VP_WIDTH_RESET = 13'd640;
    localparam logic [VP_W-1:0] VP_HEIGHT_RESET = 13'd480;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_STEP = 1'b1;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEWPORT_HEIGHT = 1'd1;

endpackage

/* design/bls_setup.sv */
module bls_setup #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  y_major,
    output logic [COORD_BITS-1:0] major_pos,
    output logic [COORD_BITS-1:0] minor_pos,
    output logic [COORD_BITS-1:0] major_end,
    output logic [COORD_BITS:0]   major_delta,
    output logic [COORD_BITS:0]   minor_delta,
    output logic                  minor_negative,
    output logic [COORD_BITS+2:0] error_term
);
    import bls_pkg::*;

    localparam int CB = COORD_BITS;

    logic [CB:0]   dx;
    logic [CB:0]   dy;
    logic [CB:0]   abs_dx;
    logic [CB:0]   abs_dy;
    logic [CB-1:0] a0;
    logic [CB-1:0] a1;
    logic [CB-1:0] b0;
    logic [CB-1:0] b1;
    logic          swap;
    logic [CB:0]   dmin;

    always_comb begin
        dx = {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
        dy = {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
        abs_dx = dx[CB] ? (~dx + 1'b1) : dx;
        abs_dy = dy[CB] ? (~dy + 1'b1) : dy;
        y_major = !(abs_dy < abs_dx);

        if (y_major) begin
            a0 = start_y;
            b0 = start_x;
            a1 = end_y;
            b1 = end_x;
        end else begin
            a0 = start_x;
            b0 = start_y;
            a1 = end_x;
            b1 = end_y;
        end

        swap = $signed(a1) < $signed(a0);
        major_pos = swap ? a1 : a0;
        major_end = swap ? a0 : a1;
        minor_pos = swap ? b1 : b0;
        major_delta = {major_end[CB-1], major_end} - {major_pos[CB-1], major_pos};
        dmin = swap ? ({b0[CB-1], b0} - {b1[CB-1], b1})
                    : ({b1[CB-1], b1} - {b0[CB-1], b0});
        minor_negative = dmin[CB];
        minor_delta = dmin[CB] ? (~dmin + 1'b1) : dmin;
        error_term = {1'b0, minor_delta, 1'b0} - {2'b00, major_delta};
    end

endmodule

/* design/bls_step.sv */
module bls_step #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                    y_major,
    input  logic [COORD_BITS-1:0]   major_pos,
    input  logic [COORD_BITS-1:0]   minor_pos,
    input  logic [COORD_BITS-1:0]   major_end,
    input  logic [COORD_BITS:0]     major_delta,
    input  logic [COORD_BITS:0]     minor_delta,
    input  logic                    minor_negative,
    input  logic [COORD_BITS+2:0]   error_term,
    input  logic [bls_pkg::VP_W-1:0] viewport_width,
    input  logic [bls_pkg::VP_W-1:0] viewport_height,
    output logic [COORD_BITS-1:0]   pixel_x,
    output logic [COORD_BITS-1:0]   pixel_y,
    output logic                    inside_view,
    output logic                    last_pixel,
    output logic [COORD_BITS-1:0]   major_pos_adv,
    output logic [COORD_BITS-1:0]   minor_pos_adv,
    output logic [COORD_BITS+2:0]   error_term_adv
);
    import bls_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int CMP_W = (CB > VP_W) ? CB : VP_W;

    logic [CMP_W-1:0] x_ext;
    logic [CMP_W-1:0] y_ext;
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] h_ext;
    logic             error_pos;

    always_comb begin
        pixel_x = y_major ? minor_pos : major_pos;
        pixel_y = y_major ? major_pos : minor_pos;

        x_ext = CMP_W'(pixel_x);
        y_ext = CMP_W'(pixel_y);
        w_ext = CMP_W'(viewport_width);
        h_ext = CMP_W'(viewport_height);
        inside_view = !pixel_x[CB-1] && !pixel_y[CB-1] && (x_ext < w_ext) && (y_ext < h_ext);

        last_pixel = !($signed(major_pos) < $signed(major_end));

        error_pos = !error_term[CB+2] && (|error_term);
        major_pos_adv = major_pos + 1'b1;
        if (error_pos) begin
            minor_pos_adv = minor_negative ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
            error_term_adv = error_term + {1'b0, minor_delta, 1'b0}
                             - {1'b0, major_delta, 1'b0};
        end else begin
            minor_pos_adv = minor_pos;
            error_term_adv = error_term + {1'b0, minor_delta, 1'b0};
        end
    end

endmodule

/* design/bresenham_line_stepper.sv */
// Bresenham line stepper. A word on the input channel with s_action at start
// loads two endpoints and produces no result. Each word with s_action at step
// produces one result word carrying the current pixel, its viewport flag and
// a last-pixel flag, and then advances the line by one unit on the major axis.
// A step with no line in progress returns a word with m_line_active low and
// all other fields zero. After the last pixel the line is finished.
// The viewport size is set through cfg_we, cfg_index and cfg_wdata; index 0 is
// the width and index 1 the height. The user must write it only while the
// block is idle; the block itself does not enforce this. A result appears on
// the m_ channel in the cycle after its step word is accepted, held in an
// output register. One word per cycle is accepted while no result is stalled,
// as the setup and step logic feeding the state registers is combinational.
// While the receiver stalls with a result pending, s_ready stays low and the
// pending word is held unchanged. Reset ends any line in progress, empties the
// output register and restores the viewport to 640 by 480.
module bresenham_line_stepper #(
    parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bls_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bls_pkg::VP_W-1:0]       cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [COORD_BITS-1:0]          s_start_x,
    input  logic [COORD_BITS-1:0]          s_start_y,
    input  logic [COORD_BITS-1:0]          s_end_x,
    input  logic [COORD_BITS-1:0]          s_end_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [COORD_BITS-1:0]          m_pixel_x,
    output logic [COORD_BITS-1:0]          m_pixel_y,
    output logic                           m_inside_view,
    output logic                           m_last_pixel,
    output logic                           m_line_active
);
    import bls_pkg::*;

    localparam int CB = COORD_BITS;

    logic [VP_W-1:0] vp_width_reg;
    logic [VP_W-1:0] vp_height_reg;

    logic          busy_reg;
    logic          y_major_reg;
    logic [CB-1:0] major_pos_reg;
    logic [CB-1:0] minor_pos_reg;
    logic [CB-1:0] major_end_reg;
    logic [CB:0]   major_delta_reg;
    logic [CB:0]   minor_delta_reg;
    logic          minor_negative_reg;
    logic [CB+2:0] error_term_reg;

    logic          m_valid_reg;
    logic [CB-1:0] m_pixel_x_reg;
    logic [CB-1:0] m_pixel_y_reg;
    logic          m_inside_view_reg;
    logic          m_last_pixel_reg;
    logic          m_line_active_reg;

    logic          accept;
    logic          su_y_major;
    logic [CB-1:0] su_major_pos;
    logic [CB-1:0] su_minor_pos;
    logic [CB-1:0] su_major_end;
    logic [CB:0]   su_major_delta;
    logic [CB:0]   su_minor_delta;
    logic          su_minor_negative;
    logic [CB+2:0] su_error_term;

    logic [CB-1:0] st_pixel_x;
    logic [CB-1:0] st_pixel_y;
    logic          st_inside_view;
    logic          st_last_pixel;
    logic [CB-1:0] st_major_pos;
    logic [CB-1:0] st_minor_pos;
    logic [CB+2:0] st_error_term;

    bls_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .start_x       (s_start_x),
        .start_y       (s_start_y),
        .end_x         (s_end_x),
        .end_y         (s_end_y),
        .y_major       (su_y_major),
        .major_pos     (su_major_pos),
        .minor_pos     (su_minor_pos),
        .major_end     (su_major_end),
        .major_delta   (su_major_delta),
        .minor_delta   (su_minor_delta),
        .minor_negative(su_minor_negative),
        .error_term    (su_error_term)
    );

    bls_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .y_major        (y_major_reg),
        .major_pos      (major_pos_reg),
        .minor_pos      (minor_pos_reg),
        .major_end      (major_end_reg),
        .major_delta    (major_delta_reg),
        .minor_delta    (minor_delta_reg),
        .minor_negative (minor_negative_reg),
        .error_term     (error_term_reg),
        .viewport_width (vp_width_reg),
        .viewport_height(vp_height_reg),
        .pixel_x        (st_pixel_x),
        .pixel_y        (st_pixel_y),
        .inside_view    (st_inside_view),
        .last_pixel     (st_last_pixel),
        .major_pos_adv  (st_major_pos),
        .minor_pos_adv  (st_minor_pos),
        .error_term_adv (st_error_term)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_width_reg <= VP_WIDTH_RESET;
            vp_height_reg <= VP_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VIEWPORT_WIDTH: vp_width_reg <= cfg_wdata;
                REG_VIEWPORT_HEIGHT: vp_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            if (s_action == ACTION_START) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && st_last_pixel) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_action == ACTION_START) begin
                y_major_reg <= su_y_major;
                major_pos_reg <= su_major_pos;
                minor_pos_reg <= su_minor_pos;
                major_end_reg <= su_major_end;
                major_delta_reg <= su_major_delta;
                minor_delta_reg <= su_minor_delta;
                minor_negative_reg <= su_minor_negative;
                error_term_reg <= su_error_term;
            end else if (busy_reg && !st_last_pixel) begin
                major_pos_reg <= st_major_pos;
                minor_pos_reg <= st_minor_pos;
                error_term_reg <= st_error_term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_action == ACTION_STEP) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_action == ACTION_STEP) begin
            if (busy_reg) begin
                m_pixel_x_reg <= st_pixel_x;
                m_pixel_y_reg <= st_pixel_y;
                m_inside_view_reg <= st_inside_view;
                m_last_pixel_reg <= st_last_pixel;
                m_line_active_reg <= 1'b1;
            end else begin
                m_pixel_x_reg <= '0;
                m_pixel_y_reg <= '0;
                m_inside_view_reg <= 1'b0;
                m_last_pixel_reg <= 1'b0;
                m_line_active_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pixel_x = m_pixel_x_reg;
    assign m_pixel_y = m_pixel_y_reg;
    assign m_inside_view = m_inside_view_reg;
    assign m_last_pixel = m_last_pixel_reg;
    assign m_line_active = m_line_active_reg;

endmodule

/* verif/tb_bresenham_line_stepper.sv */
module tb_bresenham_line_stepper;
    import bls_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        logic   action;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
    } line_word_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   in_view;
        logic   last;
        logic   active;
    } pixel_t;

    typedef enum logic {RX_OPEN, RX_CHOPPY} rx_mode_e;
    typedef enum logic {TX_STEADY, TX_BURSTY} tx_mode_e;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_VIEWPORT_WIDTH;
    logic [VP_W-1:0]        cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_action = ACTION_START;
    logic [CB-1:0]          s_start_x = '0;
    logic [CB-1:0]          s_start_y = '0;
    logic [CB-1:0]          s_end_x = '0;
    logic [CB-1:0]          s_end_y = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [CB-1:0]          m_pixel_x;
    logic [CB-1:0]          m_pixel_y;
    logic                   m_inside_view;
    logic                   m_last_pixel;
    logic                   m_line_active;

    bresenham_line_stepper #(
        .COORD_BITS(CB)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_start_x(s_start_x),
        .s_start_y(s_start_y),
        .s_end_x(s_end_x),
        .s_end_y(s_end_y),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pixel_x(m_pixel_x),
        .m_pixel_y(m_pixel_y),
        .m_inside_view(m_inside_view),
        .m_last_pixel(m_last_pixel),
        .m_line_active(m_line_active)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Line state kept alongside the block, updated at each accepted word.
    logic              ln_busy = 1'b0;
    logic              ln_y_major = 1'b0;
    logic              ln_minor_neg = 1'b0;
    coord_t            ln_major = '0;
    coord_t            ln_minor = '0;
    coord_t            ln_major_end = '0;
    logic [CB:0]       ln_major_delta = '0;
    logic [CB:0]       ln_minor_delta = '0;
    logic signed [CB+2:0] ln_error = '0;
    logic [VP_W-1:0]   vp_width = VP_WIDTH_RESET;
    logic [VP_W-1:0]   vp_height = VP_HEIGHT_RESET;

    pixel_t   pixels_due[$];
    int       mismatches = 0;
    int       cycle_count = 0;
    int       rx_hold = 0;
    rx_mode_e rx_mode = RX_OPEN;
    tx_mode_e tx_mode = TX_STEADY;
    int       burst_left = 0;
    logic     offering = 1'b0;

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic trace_line_word(input line_word_t w);
        int x0, y0, x1, y1, a0, b0, a1, b1, t, dmin, e, m, px, py, wv, hv;
        pixel_t p;
        if (w.action == ACTION_START) begin
            x0 = w.sx;
            y0 = w.sy;
            x1 = w.ex;
            y1 = w.ey;
            ln_y_major = !(abs_int(y1 - y0) < abs_int(x1 - x0));
            if (ln_y_major) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a1 < a0) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            dmin = b1 - b0;
            ln_major = coord_t'(a0);
            ln_minor = coord_t'(b0);
            ln_major_end = coord_t'(a1);
            ln_major_delta = (CB+1)'(a1 - a0);
            ln_minor_neg = dmin < 0;
            ln_minor_delta = (CB+1)'(abs_int(dmin));
            ln_error = (CB+3)'(2 * abs_int(dmin) - (a1 - a0));
            ln_busy = 1'b1;
            return;
        end
        p = '{default: '0};
        if (ln_busy) begin
            px = ln_y_major ? ln_minor : ln_major;
            py = ln_y_major ? ln_major : ln_minor;
            wv = int'(vp_width);
            hv = int'(vp_height);
            p.x = coord_t'(px);
            p.y = coord_t'(py);
            p.in_view = (px >= 0) && (px < wv) && (py >= 0) && (py < hv);
            p.last = ln_major >= ln_major_end;
            p.active = 1'b1;
            if (p.last) begin
                ln_busy = 1'b0;
            end else begin
                e = int'(ln_error);
                m = int'(ln_minor);
                if (e > 0) begin
                    m += ln_minor_neg ? -1 : 1;
                    e += 2 * (int'(ln_minor_delta) - int'(ln_major_delta));
                end else begin
                    e += 2 * int'(ln_minor_delta);
                end
                ln_minor = coord_t'(m);
                ln_error = (CB+3)'(e);
                ln_major = coord_t'(int'(ln_major) + 1);
            end
        end
        pixels_due.push_back(p);
    endtask

    function automatic line_word_t start_word(input coord_t x0, input coord_t y0,
                                              input coord_t x1, input coord_t y1);
        line_word_t w;
        w.action = ACTION_START;
        w.sx = x0;
        w.sy = y0;
        w.ex = x1;
        w.ey = y1;
        return w;
    endfunction

    function automatic line_word_t step_word();
        line_word_t w;
        w.action = ACTION_STEP;
        w.sx = coord_t'($urandom);
        w.sy = coord_t'($urandom);
        w.ex = coord_t'($urandom);
        w.ey = coord_t'($urandom);
        return w;
    endfunction

    // Mostly near zero or near the far viewport edge, sometimes anywhere.
    function automatic coord_t pick_coord(input int edge_pos);
        int r, v;
        coord_t c;
        r = $urandom_range(0, 9);
        v = $urandom_range(0, 40);
        if (r < 4) begin
            v = v - 20;
        end else if (r < 8) begin
            v = edge_pos + v - 20;
        end else begin
            v = $urandom;
        end
        c = coord_t'(v);
        return c;
    endfunction

    task automatic send_word(input line_word_t w);
        s_valid <= 1'b1;
        s_action <= w.action;
        s_start_x <= w.sx;
        s_start_y <= w.sy;
        s_end_x <= w.ex;
        s_end_y <= w.ey;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        trace_line_word(w);
    endtask

    task automatic withdraw();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic pace();
        int g, n;
        if (tx_mode == TX_STEADY) begin
            return;
        end
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 24);
        g = $urandom_range(0, 9);
        if (g < 6) begin
            n = $urandom_range(1, 3);
        end else if (g < 9) begin
            n = $urandom_range(4, 15);
        end else begin
            n = 0;
        end
        if (n > 0) begin
            withdraw();
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        withdraw();
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_viewport(input int w, input int h);
        cfg_we <= 1'b1;
        cfg_index <= REG_VIEWPORT_WIDTH;
        cfg_wdata <= VP_W'(w);
        @(posedge aclk);
        cfg_index <= REG_VIEWPORT_HEIGHT;
        cfg_wdata <= VP_W'(h);
        @(posedge aclk);
        cfg_we <= 1'b0;
        vp_width = VP_W'(w);
        vp_height = VP_W'(h);
    endtask

    task automatic send_steps(input int n);
        repeat (n) begin
            send_word(step_word());
            pace();
        end
    endtask

    task automatic test_directed();
        rx_mode = RX_CHOPPY;
        tx_mode = TX_BURSTY;
        // A step with no line in progress, then a single-point line.
        send_steps(1);
        send_word(start_word(5, 5, 5, 5));
        send_steps(2);
        // Diagonal tie, drawn with y major and a falling minor coordinate.
        send_word(start_word(0, 0, 3, -3));
        send_steps(4);
        // Shallow line at the top corner of the range, given backwards.
        send_word(start_word(8191, 8191, 8188, 8190));
        send_steps(4);
        send_word(start_word(-8192, -8192, -8190, -8189));
        send_steps(4);
        // Full-span lines, each cut short by a new start.
        send_word(start_word(-8192, 8191, 8191, -8192));
        send_steps(2);
        send_word(start_word(8191, -8192, -8192, 8191));
        send_steps(1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_OPEN;
        tx_mode = TX_STEADY;
        rx_hold = 150;
        send_word(start_word(0, 0, 30, 7));
        send_steps(32);
        wait_idle();
    endtask

    task automatic test_random_lines(input int n_words);
        int sent, kind, len, steps, r, x0i, y0i, x1i, y1i;
        coord_t x0, y0, x1, y1;
        line_word_t w;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(0, 19);
            if (kind == 0) begin
                w = step_word();
                w.action = 1'($urandom_range(0, 1));
                send_word(w);
                pace();
                sent++;
            end else begin
                if (kind <= 3) begin
                    x0 = coord_t'($urandom);
                    y0 = coord_t'($urandom);
                    x1 = coord_t'($urandom);
                    y1 = coord_t'($urandom);
                end else begin
                    x0 = pick_coord(int'(vp_width));
                    y0 = pick_coord(int'(vp_height));
                    x1 = coord_t'(int'(x0) + int'($urandom_range(0, 40)) - 20);
                    y1 = coord_t'(int'(y0) + int'($urandom_range(0, 40)) - 20);
                end
                x0i = x0;
                y0i = y0;
                x1i = x1;
                y1i = y1;
                len = abs_int(x1i - x0i);
                if (abs_int(y1i - y0i) > len) begin
                    len = abs_int(y1i - y0i);
                end
                steps = len + 1;
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    steps += $urandom_range(1, 2);
                end else if (r < 3) begin
                    steps = $urandom_range(0, len);
                end
                if (len > 64) begin
                    steps = $urandom_range(0, 30);
                end
                send_word(start_word(x0, y0, x1, y1));
                pace();
                send_steps(steps);
                sent += steps + 1;
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_pixels
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                mismatches++;
                $display("%0t: pixel word expected none, got x=%0d y=%0d", $time,
                         $signed(m_pixel_x), $signed(m_pixel_y));
            end else begin
                want = pixels_due.pop_front();
                check_field("pixel_x", want.x, $signed(m_pixel_x));
                check_field("pixel_y", want.y, $signed(m_pixel_y));
                check_field("inside_view", want.in_view, m_inside_view);
                check_field("last_pixel", want.last, m_last_pixel);
                check_field("line_active", want.active, m_line_active);
            end
        end
    end

    initial begin : receiver
        int run_left;
        logic run_level;
        run_left = 0;
        run_level = 1'b1;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_mode == RX_OPEN) begin
                m_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_level = ($urandom_range(0, 2) != 0);
                    run_left = $urandom_range(1, 10);
                end
                m_ready <= run_level;
                run_left--;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : main
        int widths[5];
        int heights[5];
        widths = '{1, 8191, 0, 100, 1};
        heights = '{1, 8191, 37, 0, 1};
        widths[4] = $urandom_range(1, 8191);
        heights[4] = $urandom_range(1, 8191);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        for (int i = 0; i < 5; i++) begin
            set_viewport(widths[i], heights[i]);
            rx_mode = (i % 2 == 1) ? RX_CHOPPY : RX_OPEN;
            tx_mode = (i == 2) ? TX_STEADY : TX_BURSTY;
            test_random_lines(400);
            wait_idle();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
design/bls_pkg.sv
design/bls_setup.sv
design/bls_step.sv
design/bresenham_line_stepper.sv
verif/tb_bresenham_line_stepper.sv
